// ----- sv/swbs_pkg.sv -----
// ----------------------------------------------------------------------------
// swbs_pkg
// Shared sizes, codes and control structures for the sorted word table.
// ----------------------------------------------------------------------------
package swbs_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_CHARS   = 64;

  localparam int ENT_W    = $clog2(MAX_ENTRIES);
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int CH_W     = $clog2(MAX_CHARS);
  localparam int LEN_W    = $clog2(MAX_CHARS + 1);
  localparam int WS_DEPTH = MAX_ENTRIES * MAX_CHARS;
  localparam int WS_AW    = $clog2(WS_DEPTH);

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ENTRY = 2'd1,
    ACT_KEY   = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_FOUND     = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_STORED    = 3'd2,
    STS_FULL      = 3'd3,
    STS_TOO_LONG  = 3'd4
  } out_status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PROBE = 2'd1,
    ST_LEN   = 2'd2,
    ST_CMP   = 2'd3
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;
    logic probe;
    logic load_len;
    logic step;
    logic narrow;
    logic found;
    logic miss;
  } swbs_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic srch_start;
    logic range_empty;
    logic cmp_done;
    logic cmp_eq;
    logic out_busy;
  } swbs_sts_t;

endpackage

// ----- sv/sorted_word_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_word_table_binary_search
// Sorted byte-string table loaded one byte per word, searched by binary search.
// ----------------------------------------------------------------------------
// A stored, full or too-long result is valid the cycle after the final byte.
// A search runs at most 11 probes over 1024 entries; each probe picks the
// middle entry, latches its length and then compares bytes up to
// min(entry length, key length) or the first difference.
// One search runs at a time; the probe loop reads the word store
// one byte per cycle. Reset empties the table at once.
// ----------------------------------------------------------------------------
module sorted_word_table_binary_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [swbs_pkg::ACTION_W-1:0]     in_action,
  input  logic [swbs_pkg::CHAR_W-1:0]       in_char_byte,
  input  logic                              in_last_char,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swbs_pkg::STATUS_W-1:0]     out_status,
  output logic [swbs_pkg::INDEX_W-1:0]      out_index
);
  import swbs_pkg::*;

  // The controller only talks to the datapath through these two bundles.
  // Words are taken only in the idle state and only while the result
  // register is free or being emptied, so a result can never be overwritten.
  swbs_cmd_t cmd;
  swbs_sts_t sts;

  // The controller walks each probe through three phases: pick the middle
  // entry and read its length, latch the length and the compare count, then
  // stream entry and key bytes through the comparator until a difference or
  // the shorter string ends. The outcome moves one bound or ends the search.
  swbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the word store, the entry lengths and the key buffer
  // in RAMs, together with the counters, the search bounds and the result
  // register. Entries refused as too long still write their bytes into the
  // slot past the last stored entry, which is harmless as that slot is
  // rewritten before it can ever be searched.
  swbs_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_action    (in_action),
    .in_char_byte (in_char_byte),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_index    (out_index),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ----- sv/swbs_ram.sv -----
// ----------------------------------------------------------------------------
// swbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module swbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/swbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// swbs_ctrl
// Search sequencer: accepts words, then steps probes of the binary search.
// ----------------------------------------------------------------------------
module swbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swbs_pkg::swbs_sts_t sts,
  output swbs_pkg::swbs_cmd_t cmd
);
  import swbs_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        take_in;

  assign in_ready = (state_r == ST_IDLE) && !sts.out_busy;
  assign take_in  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take_in && sts.srch_start) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_nxt = sts.range_empty ? ST_IDLE : ST_LEN;
      end
      ST_LEN: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.cmp_done) begin
          state_nxt = sts.cmp_eq ? ST_IDLE : ST_PROBE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.take_in = take_in;
    case (state_r)
      ST_PROBE: begin
        cmd.probe = !sts.range_empty;
        cmd.miss  = sts.range_empty;
      end
      ST_LEN: begin
        cmd.load_len = 1'b1;
      end
      ST_CMP: begin
        cmd.step   = 1'b1;
        cmd.found  = sts.cmp_done && sts.cmp_eq;
        cmd.narrow = sts.cmp_done && !sts.cmp_eq;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/swbs_dpath.sv -----
// ----------------------------------------------------------------------------
// swbs_dpath
// Word store, length and key memories, search bounds, byte comparator and
// the result register.
// ----------------------------------------------------------------------------
module swbs_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [swbs_pkg::ACTION_W-1:0]       in_action,
  input  logic [swbs_pkg::CHAR_W-1:0]         in_char_byte,
  input  logic                                in_last_char,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swbs_pkg::STATUS_W-1:0]       out_status,
  output logic [swbs_pkg::INDEX_W-1:0]        out_index,
  input  swbs_pkg::swbs_cmd_t                 cmd,
  output swbs_pkg::swbs_sts_t                 sts
);
  import swbs_pkg::*;

  // Table bookkeeping.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] klen_r, klen_nxt;
  logic             ovf_r, ovf_nxt;

  // Search state.
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [ENT_W-1:0] mid_r, mid_nxt;
  logic [LEN_W-1:0] kl_r, kl_nxt;
  logic [LEN_W-1:0] el_r, el_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             vld_r, vld_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;

  // Memory ports.
  logic             ws_we, len_we, key_we;
  logic [WS_AW-1:0] ws_waddr, ws_raddr;
  logic [CHAR_W-1:0] ws_rdata, key_rdata;
  logic [LEN_W-1:0] len_rdata;

  logic [CNT_W:0]   mid_sum;
  logic [ENT_W-1:0] mid_c;
  logic             full;
  logic             diff;
  logic             cmp_done;
  logic             cmp_lt;
  logic [LEN_W-1:0] fill_inc;
  logic [LEN_W-1:0] klen_inc;

  // Probe point (lo + hi - 1) / 2 with hi held as an exclusive bound.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W + 1)'(1);
  assign mid_c   = ENT_W'(mid_sum >> 1);

  assign full     = (count_r == CNT_W'(MAX_ENTRIES));
  assign fill_inc = fill_r + LEN_W'(1);
  assign klen_inc = klen_r + LEN_W'(1);

  assign ws_waddr = WS_AW'(count_r[ENT_W-1:0]) * WS_AW'(MAX_CHARS) + WS_AW'(fill_r);
  assign ws_raddr = WS_AW'(mid_r) * WS_AW'(MAX_CHARS) + WS_AW'(rd_idx_r);

  assign diff     = vld_r && (ws_rdata != key_rdata);
  assign cmp_done = diff || (rd_idx_r == n_r);
  assign cmp_lt   = diff ? (ws_rdata < key_rdata) : (el_r < kl_r);

  assign sts.range_empty = !(lo_r < hi_r);
  assign sts.cmp_done    = cmp_done;
  assign sts.cmp_eq      = !diff && (el_r == kl_r);
  assign sts.out_busy    = out_valid_r && !out_ready;
  assign sts.srch_start  = (in_action == ACT_KEY) && in_last_char && !ovf_r
                           && (klen_r < LEN_W'(MAX_CHARS));

  always_comb begin
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    klen_nxt       = klen_r;
    ovf_nxt        = ovf_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    kl_nxt         = kl_r;
    el_nxt         = el_r;
    n_nxt          = n_r;
    rd_idx_nxt     = rd_idx_r;
    vld_nxt        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    ws_we          = 1'b0;
    len_we         = 1'b0;
    key_we         = 1'b0;

    if (cmd.take_in) begin
      case (in_action)
        ACT_CLEAR: begin
          count_nxt = '0;
          fill_nxt  = '0;
          klen_nxt  = '0;
          ovf_nxt   = 1'b0;
        end
        ACT_ENTRY: begin
          if (!full) begin
            if (fill_r < LEN_W'(MAX_CHARS)) begin
              ws_we    = 1'b1;
              fill_nxt = fill_inc;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_last_char) begin
            out_valid_nxt = 1'b1;
            out_index_nxt = '0;
            if (full) begin
              out_status_nxt = STS_FULL;
            end else if (ovf_nxt) begin
              out_status_nxt = STS_TOO_LONG;
            end else begin
              len_we         = 1'b1;
              out_status_nxt = STS_STORED;
              out_index_nxt  = INDEX_W'(count_r);
              count_nxt      = count_r + CNT_W'(1);
            end
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end
        ACT_KEY: begin
          if (klen_r < LEN_W'(MAX_CHARS)) begin
            key_we   = 1'b1;
            klen_nxt = klen_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_char) begin
            if (ovf_nxt) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_TOO_LONG;
              out_index_nxt  = '0;
            end else begin
              kl_nxt = klen_inc;
              lo_nxt = '0;
              hi_nxt = count_r;
            end
            klen_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.probe) begin
      mid_nxt = mid_c;
    end

    if (cmd.load_len) begin
      el_nxt     = len_rdata;
      n_nxt      = (len_rdata < kl_r) ? len_rdata : kl_r;
      rd_idx_nxt = '0;
    end

    if (cmd.step && !cmp_done) begin
      rd_idx_nxt = rd_idx_r + LEN_W'(1);
      vld_nxt    = 1'b1;
    end

    if (cmd.narrow) begin
      if (cmp_lt) begin
        lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
      end else begin
        hi_nxt = CNT_W'(mid_r);
      end
    end

    if (cmd.found) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STS_FOUND;
      out_index_nxt  = INDEX_W'(mid_r);
    end

    if (cmd.miss) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STS_NOT_FOUND;
      out_index_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fill_r      <= '0;
      klen_r      <= '0;
      ovf_r       <= 1'b0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      klen_r      <= klen_nxt;
      ovf_r       <= ovf_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    kl_r         <= kl_nxt;
    el_r         <= el_nxt;
    n_r          <= n_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  swbs_ram #(.WIDTH(CHAR_W), .DEPTH(WS_DEPTH)) u_word_ram (
    .clk   (clk),
    .we    (ws_we),
    .waddr (ws_waddr),
    .wdata (in_char_byte),
    .raddr (ws_raddr),
    .rdata (ws_rdata)
  );

  swbs_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (count_r[ENT_W-1:0]),
    .wdata (fill_inc),
    .raddr (mid_c),
    .rdata (len_rdata)
  );

  swbs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_CHARS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (klen_r[CH_W-1:0]),
    .wdata (in_char_byte),
    .raddr (rd_idx_r[CH_W-1:0]),
    .rdata (key_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;

endmodule
